// ----- rtl/core/lad_pkg.sv -----
package lad_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_SHOW       = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               last;
    } t_rsp;

    // Controller to datapath.
    typedef struct packed {
        logic take;       // input transaction accepted this cycle
        logic pop_load;   // move popped word into the output register
        logic show_rd;    // read the entry under the show pointer
        logic show_load;  // move listed word into the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic slot_free;  // output register can take a word this cycle
        logic pop_go;     // pending request is a pop on a non-empty deque
        logic show_go;    // pending request is a show on a non-empty deque
        logic show_last;  // show pointer sits on the rear entry
    } t_stat;

endpackage

// ----- rtl/core/lad_ctrl.sv -----
module lad_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lad_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output lad_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_POP      = 2'd1;
    localparam logic [1:0] S_SHOW_RD  = 2'd2;
    localparam logic [1:0] S_SHOW_OUT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.slot_free;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid && o_in_ready;
                if (o_cmd.take) begin
                    if (i_stat.pop_go) begin
                        n_state = S_POP;
                    end else if (i_stat.show_go) begin
                        n_state = S_SHOW_RD;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_load = i_stat.slot_free;
                if (i_stat.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SHOW_RD: begin
                o_cmd.show_rd = 1'b1;
                n_state       = S_SHOW_OUT;
            end
            S_SHOW_OUT: begin
                o_cmd.show_load = i_stat.slot_free;
                if (i_stat.slot_free) begin
                    n_state = i_stat.show_last ? S_IDLE : S_SHOW_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/lad_dpath.sv -----
module lad_dpath #(
    parameter int DEPTH = lad_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lad_pkg::t_req   i_req,
    input  lad_pkg::t_cmd   i_cmd,
    input  logic            i_out_ready,
    output lad_pkg::t_stat  o_stat,
    output logic            o_out_valid,
    output lad_pkg::t_rsp   o_out_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] TOP_IDX = AW'(DEPTH - 1);

    logic signed [31:0] mem [DEPTH];

    logic [AW-1:0]      r_front, n_front;
    logic [AW-1:0]      r_rear, n_rear;
    logic               r_empty, n_empty;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic               r_out_valid, n_out_valid;
    lad_pkg::t_rsp      r_out, n_out;
    logic signed [31:0] r_rdata;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               is_pop;
    logic               out_load;

    assign is_pop = (i_req.req_type == lad_pkg::REQ_POP_FRONT)
                 || (i_req.req_type == lad_pkg::REQ_POP_BACK);

    assign o_stat.slot_free = !r_out_valid || i_out_ready;
    assign o_stat.pop_go    = is_pop && !r_empty;
    assign o_stat.show_go   = (i_req.req_type == lad_pkg::REQ_SHOW) && !r_empty;
    assign o_stat.show_last = (r_ptr == r_rear);

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_empty  = r_empty;
        n_ptr    = r_ptr;
        n_out    = r_out;
        out_load = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        rd_en    = 1'b0;
        rd_addr  = r_ptr;

        if (i_cmd.take) begin
            case (i_req.req_type)
                lad_pkg::REQ_PUSH_FRONT, lad_pkg::REQ_PUSH_BACK: begin
                    out_load    = 1'b1;
                    n_out.last  = 1'b1;
                    n_out.data  = i_req.value;
                    n_out.status = lad_pkg::ST_OK;
                    if (r_empty) begin
                        n_front = '0;
                        n_rear  = '0;
                        n_empty = 1'b0;
                        wr_en   = 1'b1;
                        wr_addr = '0;
                    end else if (i_req.req_type == lad_pkg::REQ_PUSH_FRONT) begin
                        if (r_front != '0) begin
                            n_front = r_front - AW'(1);
                            wr_en   = 1'b1;
                            wr_addr = r_front - AW'(1);
                        end else begin
                            n_out.data   = '0;
                            n_out.status = lad_pkg::ST_OVERFLOW;
                        end
                    end else begin
                        if (r_rear != TOP_IDX) begin
                            n_rear  = r_rear + AW'(1);
                            wr_en   = 1'b1;
                            wr_addr = r_rear + AW'(1);
                        end else begin
                            n_out.data   = '0;
                            n_out.status = lad_pkg::ST_OVERFLOW;
                        end
                    end
                end
                lad_pkg::REQ_POP_FRONT, lad_pkg::REQ_POP_BACK, lad_pkg::REQ_SHOW: begin
                    if (r_empty) begin
                        out_load     = 1'b1;
                        n_out.data   = '0;
                        n_out.status = lad_pkg::ST_EMPTY;
                        n_out.last   = 1'b1;
                    end else if (i_req.req_type == lad_pkg::REQ_SHOW) begin
                        n_ptr = r_front;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = (i_req.req_type == lad_pkg::REQ_POP_FRONT) ? r_front
                                                                             : r_rear;
                        if (r_front == r_rear) begin
                            n_front = '0;
                            n_rear  = '0;
                            n_empty = 1'b1;
                        end else if (i_req.req_type == lad_pkg::REQ_POP_FRONT) begin
                            n_front = r_front + AW'(1);
                        end else begin
                            n_rear = r_rear - AW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.show_rd) begin
            rd_en   = 1'b1;
            rd_addr = r_ptr;
        end

        if (i_cmd.pop_load || i_cmd.show_load) begin
            out_load     = 1'b1;
            n_out.data   = r_rdata;
            n_out.status = lad_pkg::ST_OK;
            n_out.last   = i_cmd.pop_load || (r_ptr == r_rear);
        end

        // The pointer never steps past the rear, so no wrap check is needed.
        if (i_cmd.show_load && (r_ptr != r_rear)) begin
            n_ptr = r_ptr + AW'(1);
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_req.value;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_rear      <= '0;
            r_empty     <= 1'b1;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_empty     <= n_empty;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

// ----- rtl/core/linear_array_deque.sv -----
// Channel   Direction  Handshake                    Payload
// request   in         i_in_valid / o_in_ready      i_in_req  (lad_pkg::t_req)
// response  out        o_out_valid / i_out_ready    o_out_rsp (lad_pkg::t_rsp)
//
// A push, a failed request or a request on an empty deque puts its response in the output
// register at the edge that accepts it. A pop reads the store into a read register and loads
// the output register from it once that register is free. A show lists each stored word by a
// store read, then an output load; no request is taken until the last word is out.
// Reset is synchronous and needs no clearing pass: only indices and control are cleared.
// A stalled output register holds the design in place; a new request waits for it to drain.
module linear_array_deque #(
    parameter int DEPTH = lad_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lad_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lad_pkg::t_rsp o_out_rsp
);

    lad_pkg::t_cmd  cmd;
    lad_pkg::t_stat stat;

    lad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    lad_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

    // A request is only taken when its response has somewhere to go.
    a_ready_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("request accepted while output register is blocked");

    // Pushes answer at once.
    a_push_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_req.req_type == lad_pkg::REQ_PUSH_FRONT
            || i_in_req.req_type == lad_pkg::REQ_PUSH_BACK)) |=> o_out_valid)
        else $error("push transaction produced no response");

    a_error_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status != lad_pkg::ST_OK) |-> (o_out_rsp.data == '0))
        else $error("error response carries nonzero data");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status != lad_pkg::ST_OK) |-> o_out_rsp.last)
        else $error("error response is not marked last");

endmodule

// ----- tb/lad_checker.sv -----
module lad_checker #(
    parameter int DEPTH = lad_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  lad_pkg::t_req i_in_req,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  lad_pkg::t_rsp i_out_rsp,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW = $clog2(DEPTH);

    logic signed [31:0] words [DEPTH];
    logic [IW-1:0]      head_idx = '0;
    logic [IW-1:0]      tail_idx = '0;
    logic               is_vacant = 1'b1;

    lad_pkg::t_rsp rsp_due [$];
    int            fails   = 0;
    int            checked = 0;

    function automatic void queue_answer(logic signed [31:0] word, logic [1:0] status,
                                         logic last);
        lad_pkg::t_rsp rsp;
        rsp.data   = word;
        rsp.status = status;
        rsp.last   = last;
        rsp_due.push_back(rsp);
    endfunction

    function automatic void clear_deque();
        head_idx  = '0;
        tail_idx  = '0;
        is_vacant = 1'b1;
    endfunction

    function automatic void apply_request(lad_pkg::t_req req);
        logic signed [31:0] word;
        int                 i;
        case (req.req_type)
            lad_pkg::REQ_PUSH_FRONT: begin
                if (is_vacant) begin
                    words[0]  = req.value;
                    head_idx  = '0;
                    tail_idx  = '0;
                    is_vacant = 1'b0;
                    queue_answer(req.value, lad_pkg::ST_OK, 1'b1);
                end else if (head_idx != '0) begin
                    head_idx        = head_idx - IW'(1);
                    words[head_idx] = req.value;
                    queue_answer(req.value, lad_pkg::ST_OK, 1'b1);
                end else begin
                    queue_answer('0, lad_pkg::ST_OVERFLOW, 1'b1);
                end
            end
            lad_pkg::REQ_PUSH_BACK: begin
                if (is_vacant) begin
                    words[0]  = req.value;
                    head_idx  = '0;
                    tail_idx  = '0;
                    is_vacant = 1'b0;
                    queue_answer(req.value, lad_pkg::ST_OK, 1'b1);
                end else if (int'(tail_idx) >= DEPTH - 1) begin
                    queue_answer('0, lad_pkg::ST_OVERFLOW, 1'b1);
                end else begin
                    tail_idx        = tail_idx + IW'(1);
                    words[tail_idx] = req.value;
                    queue_answer(req.value, lad_pkg::ST_OK, 1'b1);
                end
            end
            lad_pkg::REQ_POP_FRONT: begin
                if (is_vacant) begin
                    queue_answer('0, lad_pkg::ST_EMPTY, 1'b1);
                end else begin
                    word = words[head_idx];
                    if (head_idx == tail_idx) clear_deque();
                    else head_idx = head_idx + IW'(1);
                    queue_answer(word, lad_pkg::ST_OK, 1'b1);
                end
            end
            lad_pkg::REQ_POP_BACK: begin
                if (is_vacant) begin
                    queue_answer('0, lad_pkg::ST_EMPTY, 1'b1);
                end else begin
                    word = words[tail_idx];
                    if (head_idx == tail_idx) clear_deque();
                    else tail_idx = tail_idx - IW'(1);
                    queue_answer(word, lad_pkg::ST_OK, 1'b1);
                end
            end
            lad_pkg::REQ_SHOW: begin
                if (is_vacant) begin
                    queue_answer('0, lad_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (i = int'(head_idx); i <= int'(tail_idx); i++) begin
                        queue_answer(words[i], lad_pkg::ST_OK, i == int'(tail_idx));
                    end
                end
            end
            default: ;  // Unused codes leave the deque alone and answer nothing.
        endcase
    endfunction

    function automatic void check_answer(lad_pkg::t_rsp got);
        lad_pkg::t_rsp want;
        checked++;
        if (rsp_due.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("[%0t] unexpected response: data=%0d status=%0d last=%0d",
                         $realtime, got.data, got.status, got.last);
            end
        end else begin
            want = rsp_due.pop_front();
            if (got.data !== want.data || got.status !== want.status ||
                got.last !== want.last) begin
                fails++;
                if (fails <= 10) begin
                    $display({"[%0t] response mismatch: expected data=%0d status=%0d ",
                              "last=%0d, got data=%0d status=%0d last=%0d"},
                             $realtime, want.data, want.status, want.last,
                             got.data, got.status, got.last);
                end
            end
        end
    endfunction

    // A response accepted on the same edge as a request belongs to an older
    // request, so it is checked before the new request is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_deque();
        end else begin
            if (i_out_valid && i_out_ready) check_answer(i_out_rsp);
            if (i_in_valid && i_in_ready) apply_request(i_in_req);
        end
        o_fail_count <= fails;
        o_pending    <= rsp_due.size();
        o_checked    <= checked;
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RANDOM_ITEMS     = 190;
    localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;

    typedef enum int {
        MIX_FILL_BACK,
        MIX_DRAIN_FRONT,
        MIX_FILL_FRONT,
        MIX_DRAIN_BACK,
        MIX_EVEN
    } t_mix;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    lad_pkg::t_req in_req    = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    lad_pkg::t_rsp out_rsp;

    int fail_count;
    int pending;
    int checked;
    logic calm      = 1'b0;
    int hold_left   = 0;
    int n_counted   = 0;
    int n_show      = 0;
    int n_ignored   = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    linear_array_deque i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp)
    );

    lad_checker #(
        .DEPTH (lad_pkg::DEPTH_DEF)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_rsp    (out_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_code(t_mix mix);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
        if (pick < 10) return lad_pkg::REQ_SHOW;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_FILL_BACK:
                return pick < 75 ? lad_pkg::REQ_PUSH_BACK :
                       pick < 85 ? lad_pkg::REQ_PUSH_FRONT :
                       pick < 93 ? lad_pkg::REQ_POP_FRONT : lad_pkg::REQ_POP_BACK;
            MIX_DRAIN_FRONT:
                return pick < 70 ? lad_pkg::REQ_POP_FRONT :
                       pick < 85 ? lad_pkg::REQ_PUSH_BACK :
                       pick < 93 ? lad_pkg::REQ_PUSH_FRONT : lad_pkg::REQ_POP_BACK;
            MIX_FILL_FRONT:
                return pick < 70 ? lad_pkg::REQ_PUSH_FRONT :
                       pick < 82 ? lad_pkg::REQ_POP_FRONT :
                       pick < 92 ? lad_pkg::REQ_PUSH_BACK : lad_pkg::REQ_POP_BACK;
            MIX_DRAIN_BACK:
                return pick < 70 ? lad_pkg::REQ_POP_BACK :
                       pick < 85 ? lad_pkg::REQ_PUSH_FRONT :
                       pick < 93 ? lad_pkg::REQ_PUSH_BACK : lad_pkg::REQ_POP_FRONT;
            default:
                return pick < 25 ? lad_pkg::REQ_PUSH_FRONT :
                       pick < 50 ? lad_pkg::REQ_PUSH_BACK :
                       pick < 75 ? lad_pkg::REQ_POP_FRONT : lad_pkg::REQ_POP_BACK;
        endcase
    endfunction

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send(input logic [2:0] code, input logic signed [31:0] word);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_req.req_type <= code;
        in_req.value    <= word;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (code > lad_pkg::REQ_SHOW) n_ignored++;
        else n_counted++;
        if (code == lad_pkg::REQ_SHOW) n_show++;
    endtask

    always @(posedge clk) begin
        if (calm) begin
            out_ready <= 1'b1;
            hold_left = 0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_left = idle_len();
        end
    end

    initial begin
        t_mix       mix;
        int         span;
        int         k;
        int         base;
        logic [2:0] code;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Requests on an empty deque.
        send(lad_pkg::REQ_POP_FRONT, rand_word());
        send(lad_pkg::REQ_POP_BACK, rand_word());
        send(lad_pkg::REQ_SHOW, rand_word());
        // Push at the front of an empty deque, then again with the front index at zero.
        send(lad_pkg::REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
        send(lad_pkg::REQ_PUSH_FRONT, -32'sd1);
        // Removing the only element returns the deque to empty.
        send(lad_pkg::REQ_POP_BACK, rand_word());
        send(lad_pkg::REQ_PUSH_BACK, 32'sh8000_0000);
        // Fill up to the top of the store; the final push overflows.
        for (k = 0; k < lad_pkg::DEPTH_DEF; k++) begin
            send(lad_pkg::REQ_PUSH_BACK, k[0] ? 32'sh5555_5555 : 32'shAAAA_AAAA);
        end
        send(lad_pkg::REQ_SHOW, rand_word());
        send(lad_pkg::REQ_POP_FRONT, rand_word());
        send(lad_pkg::REQ_PUSH_FRONT, '0);
        for (k = REQ_FIRST_UNUSED; k <= REQ_LAST_UNUSED; k++) begin
            send(3'(k), rand_word());
        end

        base = n_counted;
        span = 0;
        while (n_counted - base < RANDOM_ITEMS) begin
            if (span == 0) begin
                mix  = t_mix'($urandom_range(0, 4));
                span = $urandom_range(15, 40);
                calm <= ($urandom_range(0, 4) == 0);
            end
            span--;
            code = pick_code(mix);
            send(code, rand_word());
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d requests, %0d of them shows, plus %0d unused request codes.",
                 n_counted, n_show, n_ignored);
        $display("Checked %0d responses with %0d failures.", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lad_pkg.sv
rtl/core/lad_ctrl.sv
rtl/core/lad_dpath.sv
rtl/core/linear_array_deque.sv
tb/lad_checker.sv
tb/tb_top.sv
